[rtl/sjis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjis_pkg: shared types and constants for the Shift-JIS font address unit
// Request and result structs, lead byte ranges and ROM band bases.
// ----------------------------------------------------------------------------
package sjis_pkg;

	localparam int BYTE_W = 8;
	localparam int ADDR_W = 18;

	// Lead byte ranges
	localparam logic [BYTE_W-1:0] LEAD1_LO = 8'h81;
	localparam logic [BYTE_W-1:0] LEAD1_HI = 8'h9F;
	localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hFC;

	// Pair conversion constants
	localparam logic [BYTE_W-1:0] HI_LEAD_ADJ = 8'h40;
	localparam logic [BYTE_W-1:0] ROW_BIAS    = 8'h70;
	localparam logic [BYTE_W-1:0] TRAIL_EVEN  = 8'h9E;
	localparam logic [BYTE_W-1:0] CELL_EVEN   = 8'h7D;
	localparam logic [BYTE_W-1:0] CELL_ODD    = 8'h1F;
	localparam logic [BYTE_W-1:0] JIS_BIAS    = 8'h20;
	localparam logic [6:0]        CELLS_ROW   = 7'd94;

	// ROM band bases
	localparam logic [ADDR_W-1:0] BASE_BAND0 = 18'd0;
	localparam logic [ADDR_W-1:0] BASE_BAND1 = 18'd43584;
	localparam logic [ADDR_W-1:0] BASE_BAND2 = 18'd138464;
	localparam logic [ADDR_W-1:0] BASE_BAND3 = 18'd246944;
	localparam logic [ADDR_W-1:0] BASE_BAND4 = 18'd249952;
	localparam logic [ADDR_W-1:0] BASE_ASCII = 18'd255968;

	// Half-width printable range
	localparam logic [BYTE_W-1:0] ASCII_LO = 8'h20;
	localparam logic [BYTE_W-1:0] ASCII_HI = 8'h7F;

	// Character request handed from the byte stage to the address logic
	typedef struct packed {
		logic              pair;
		logic              builtin;
		logic [BYTE_W-1:0] lead;
		logic [BYTE_W-1:0] code;
	} sjis_req_t;

	// Glyph result
	typedef struct packed {
		logic [ADDR_W-1:0] rom_address;
		logic              wide_glyph;
		logic              builtin_font;
		logic [BYTE_W-1:0] builtin_char;
		logic              code_mapped;
	} sjis_res_t;

endpackage

[rtl/sjis_lead.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjis_lead: byte stage of the Shift-JIS font address unit
// Tracks the pending lead byte and registers one character request per pair
// or single byte; zero bytes clear the pending lead and emit nothing.
// ----------------------------------------------------------------------------
module sjis_lead (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [sjis_pkg::BYTE_W-1:0]  text_byte,
	input  logic                         use_builtin_ascii,
	input  logic                         advance,
	output logic                         req_valid_s1,
	output sjis_pkg::sjis_req_t          req_s1
);

	logic                        pending_q;
	logic [sjis_pkg::BYTE_W-1:0] held_lead_q;
	logic                        is_zero;
	logic                        is_lead;
	logic                        emit;

	// Byte classification
	assign is_zero = (text_byte == '0);
	assign is_lead = ((text_byte >= sjis_pkg::LEAD1_LO) && (text_byte <= sjis_pkg::LEAD1_HI)) ||
	                 ((text_byte >= sjis_pkg::LEAD2_LO) && (text_byte <= sjis_pkg::LEAD2_HI));
	assign emit    = accept && !is_zero && (pending_q || !is_lead);

	// Lead tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			held_lead_q <= '0;
		end else if (accept) begin
			if (is_zero || pending_q) begin
				pending_q   <= 1'b0;
				held_lead_q <= '0;
			end else if (is_lead) begin
				pending_q   <= 1'b1;
				held_lead_q <= text_byte;
			end
		end
	end

	// Request register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (advance || !req_valid_s1) begin
			req_valid_s1 <= emit;
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (emit) begin
			req_s1.pair    <= pending_q;
			req_s1.builtin <= use_builtin_ascii;
			req_s1.lead    <= held_lead_q;
			req_s1.code    <= text_byte;
		end
	end

endmodule

[rtl/sjis_addr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjis_addr: glyph address logic of the Shift-JIS font address unit
// Converts a pair to JIS row/cell and maps it through the ROM bands, or forms
// the half-width / built-in result for a single byte.
// ----------------------------------------------------------------------------
module sjis_addr (
	input  sjis_pkg::sjis_req_t req,
	output sjis_pkg::sjis_res_t res
);

	logic [sjis_pkg::BYTE_W-1:0] a_adj;
	logic [sjis_pkg::BYTE_W-1:0] b_adj;
	logic [sjis_pkg::BYTE_W-1:0] a_half;
	logic [sjis_pkg::BYTE_W-1:0] jis_row;
	logic [sjis_pkg::BYTE_W-1:0] jis_cell;
	logic [sjis_pkg::BYTE_W-1:0] row_first;
	logic [sjis_pkg::BYTE_W-1:0] row_diff;
	logic [sjis_pkg::BYTE_W-1:0] cell_diff;
	logic [sjis_pkg::ADDR_W-1:0] band_base;
	logic                        band_hit;
	logic                        cell_ok;
	logic [11:0]                 glyph_idx;
	logic [sjis_pkg::ADDR_W-1:0] pair_addr;
	logic [sjis_pkg::BYTE_W-1:0] ascii_off;
	logic                        ascii_ok;

	// Shift-JIS to JIS X 0208, 8-bit wrapping
	always_comb begin
		a_adj = req.lead;
		if (req.lead >= sjis_pkg::LEAD2_LO) begin
			a_adj = req.lead - sjis_pkg::HI_LEAD_ADJ;
		end
		b_adj = req.code;
		if (req.code[7]) begin
			b_adj = req.code - 8'd1;
		end
		a_half = (a_adj - sjis_pkg::ROW_BIAS) << 1;
		if (b_adj >= sjis_pkg::TRAIL_EVEN) begin
			jis_row  = a_half;
			jis_cell = b_adj - sjis_pkg::CELL_EVEN;
		end else begin
			jis_row  = a_half - 8'd1;
			jis_cell = b_adj - sjis_pkg::CELL_ODD;
		end
	end

	// Row band lookup; row and cell still carry the 0x20 bias here
	always_comb begin
		cell_ok   = (jis_cell >= 8'h21) && (jis_cell <= 8'h7E);
		band_hit  = 1'b1;
		row_first = 8'h21;
		band_base = sjis_pkg::BASE_BAND0;
		if ((jis_row >= 8'h21) && (jis_row <= 8'h2F)) begin
			row_first = 8'h21;
			band_base = sjis_pkg::BASE_BAND0;
		end else if ((jis_row >= 8'h30) && (jis_row <= 8'h4F)) begin
			row_first = 8'h30;
			band_base = sjis_pkg::BASE_BAND1;
		end else if ((jis_row >= 8'h50) && (jis_row <= 8'h74)) begin
			row_first = 8'h50;
			band_base = sjis_pkg::BASE_BAND2;
		end else if (jis_row == 8'h75) begin
			row_first = 8'h75;
			band_base = sjis_pkg::BASE_BAND3;
		end else if ((jis_row >= 8'h78) && (jis_row <= 8'h79)) begin
			row_first = 8'h78;
			band_base = sjis_pkg::BASE_BAND4;
		end else begin
			band_hit = 1'b0;
		end
		band_hit = band_hit && cell_ok;
	end

	// Glyph index within band: (row - first) * 94 + (cell - 1), 32 bytes each
	always_comb begin
		row_diff  = jis_row - row_first;
		cell_diff = jis_cell - 8'h21;
		glyph_idx = ({6'd0, row_diff[5:0]} * {5'd0, sjis_pkg::CELLS_ROW})
			+ {5'd0, cell_diff[6:0]};
		pair_addr = band_base + {1'b0, glyph_idx, 5'd0};
	end

	// Half-width glyph
	assign ascii_ok  = (req.code >= sjis_pkg::ASCII_LO) && (req.code <= sjis_pkg::ASCII_HI);
	assign ascii_off = req.code - sjis_pkg::ASCII_LO;

	// Result select
	always_comb begin
		res = '0;
		if (req.pair) begin
			res.wide_glyph  = 1'b1;
			res.code_mapped = band_hit;
			res.rom_address = band_hit ? pair_addr : '0;
		end else if (req.builtin) begin
			res.builtin_font = 1'b1;
			res.builtin_char = req.code;
			res.code_mapped  = 1'b1;
		end else if (ascii_ok) begin
			res.code_mapped = 1'b1;
			res.rom_address = sjis_pkg::BASE_ASCII + {7'd0, ascii_off[6:0], 4'd0};
		end
	end

endmodule

[rtl/sjis_font_rom_address_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjis_font_rom_address_unit: Shift-JIS text to font ROM glyph address
// Takes one text byte per request and returns the glyph address per character.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, text_byte): one Shift-JIS byte per
//    request. A lead byte is held and produces nothing; the next nonzero byte
//    completes the pair. A zero byte ends the string, drops any held lead and
//    produces nothing.
//  - Output channel (out_valid/out_ready): one result per character: ROM
//    address, wide/half glyph flag, built-in font flag and code, mapped flag.
//  - cfg_wr_en/cfg_wr_data write use_builtin_ascii; write only while idle.
//  - Timing: the byte that completes the character is registered in the byte
//    register, then its result in the result register, which drives out_valid.
//  - Throughput: one byte per cycle unless the receiver stalls; the byte
//    register and result register form a two-stage pipeline, so a byte is
//    taken in the same cycle a result is taken.
//  - Receiver stall: the result register holds; the byte register fills,
//    then in_ready drops until out_ready returns.
//  - Reset: clears the held lead, both pipeline valids and use_builtin_ascii.
// ----------------------------------------------------------------------------
module sjis_font_rom_address_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sjis_pkg::BYTE_W-1:0]  text_byte,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sjis_pkg::ADDR_W-1:0]  rom_address,
	output logic                         wide_glyph,
	output logic                         builtin_font,
	output logic [sjis_pkg::BYTE_W-1:0]  builtin_char,
	output logic                         code_mapped
);

	logic                use_builtin_q;
	logic                advance;
	logic                accept;
	logic                req_valid_s1;
	sjis_pkg::sjis_req_t req_s1;
	sjis_pkg::sjis_res_t res_comb;
	sjis_pkg::sjis_res_t res_s2;
	logic                res_valid_s2;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_builtin_q <= 1'b0;
		end else if (cfg_wr_en) begin
			use_builtin_q <= cfg_wr_data;
		end
	end

	// Pipeline flow control
	assign advance  = !res_valid_s2 || out_ready;
	assign in_ready = !req_valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// Byte stage
	sjis_lead u_lead (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.text_byte         (text_byte),
		.use_builtin_ascii (use_builtin_q),
		.advance           (advance),
		.req_valid_s1      (req_valid_s1),
		.req_s1            (req_s1)
	);

	// Address logic
	sjis_addr u_addr (
		.req (req_s1),
		.res (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid    = res_valid_s2;
	assign rom_address  = res_s2.rom_address;
	assign wide_glyph   = res_s2.wide_glyph;
	assign builtin_font = res_s2.builtin_font;
	assign builtin_char = res_s2.builtin_char;
	assign code_mapped  = res_s2.code_mapped;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for sjis_font_rom_address_unit
// Feeds Shift-JIS byte streams through the request channel while both sides
// idle and stall at random. A predictor of the lead/trail decode and ROM band
// mapping gives glyphs no directed row supplies; all results checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

	typedef logic [sjis_pkg::BYTE_W-1:0] byte_t;
	typedef logic [sjis_pkg::ADDR_W-1:0] addr_t;

	localparam int RESET_CYCLES    = 12;
	localparam int DRAIN_CYCLES    = 4;
	localparam int TAIL_CYCLES     = 8;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int IDLE_PCT        = 29;
	localparam int WIDE_BYTES      = 32;
	localparam int NARROW_BYTES    = 16;

	localparam byte_t END_OF_STRING = 8'h00;
	localparam byte_t TRAIL_HI_ADJ  = 8'h80;
	localparam byte_t TRAIL_LO_MIN  = 8'h40;
	localparam byte_t TRAIL_LO_MAX  = 8'h7E;
	localparam byte_t TRAIL_HI_MIN  = 8'h80;
	localparam byte_t TRAIL_HI_MAX  = 8'hFC;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		byte_t               data;
		bit                  typed;
		sjis_pkg::sjis_res_t glyph;
	} stim_row_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	byte_t text_byte;
	logic  cfg_wr_en;
	logic  cfg_wr_data;
	logic  out_valid;
	logic  out_ready;
	addr_t rom_address;
	logic  wide_glyph;
	logic  builtin_font;
	byte_t builtin_char;
	logic  code_mapped;

	// Predictor state
	logic                builtin_mode = 1'b0;
	logic                lead_held    = 1'b0;
	byte_t               held_byte    = '0;
	sjis_pkg::sjis_res_t pending_glyphs[$];

	// Typed expectation riding along with the current request
	bit                  item_typed = 1'b0;
	sjis_pkg::sjis_res_t item_glyph = '0;

	bit                jitter_on     = 1'b0;
	bit                hold_off_req  = 1'b0;
	int                n_errors      = 0;
	int                quiet_cycles  = 0;

	stim_row_t         directed_rows[28];

	sjis_font_rom_address_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rom_address  (rom_address),
		.wide_glyph   (wide_glyph),
		.builtin_font (builtin_font),
		.builtin_char (builtin_char),
		.code_mapped  (code_mapped)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Lead/trail pair to JIS row and cell, then through the five row bands
	function automatic sjis_pkg::sjis_res_t pair_glyph(input byte_t lead,
			input byte_t trail);
		byte_t               a;
		byte_t               t;
		int                  row;
		int                  jis_cell;
		int                  first;
		int                  base;
		sjis_pkg::sjis_res_t g;
		g = '0;
		g.wide_glyph = 1'b1;
		a = lead;
		t = trail;
		base = 0;
		if (a >= sjis_pkg::LEAD2_LO)
			a = a - sjis_pkg::HI_LEAD_ADJ;
		if (t >= TRAIL_HI_ADJ)
			t = t - 8'd1;
		// all steps wrap at 8 bits
		if (t >= sjis_pkg::TRAIL_EVEN) begin
			a = (a - sjis_pkg::ROW_BIAS) << 1;
			t = t - sjis_pkg::CELL_EVEN;
		end else begin
			a = ((a - sjis_pkg::ROW_BIAS) << 1) - 8'd1;
			t = t - sjis_pkg::CELL_ODD;
		end
		row      = int'(a) - int'(sjis_pkg::JIS_BIAS);
		jis_cell = int'(t) - int'(sjis_pkg::JIS_BIAS);
		first = -1;
		if (jis_cell >= 1 && jis_cell <= int'(sjis_pkg::CELLS_ROW)) begin
			if (row >= 1 && row <= 15) begin
				first = 1;  base = int'(sjis_pkg::BASE_BAND0);
			end else if (row >= 16 && row <= 47) begin
				first = 16; base = int'(sjis_pkg::BASE_BAND1);
			end else if (row >= 48 && row <= 84) begin
				first = 48; base = int'(sjis_pkg::BASE_BAND2);
			end else if (row == 85) begin
				first = 85; base = int'(sjis_pkg::BASE_BAND3);
			end else if (row >= 88 && row <= 89) begin
				first = 88; base = int'(sjis_pkg::BASE_BAND4);
			end
		end
		if (first >= 0) begin
			g.code_mapped = 1'b1;
			g.rom_address = addr_t'(((row - first) * int'(sjis_pkg::CELLS_ROW)
				+ jis_cell - 1) * WIDE_BYTES + base);
		end
		return g;
	endfunction

	// Advance the stream state by one byte; returns 1 when a glyph comes out
	function automatic bit predict_glyph(input byte_t b, output sjis_pkg::sjis_res_t g);
		g = '0;
		if (b == END_OF_STRING) begin
			lead_held = 1'b0;
			held_byte = '0;
			return 1'b0;
		end
		if (lead_held) begin
			g = pair_glyph(held_byte, b);
			lead_held = 1'b0;
			held_byte = '0;
			return 1'b1;
		end
		if ((b >= sjis_pkg::LEAD1_LO && b <= sjis_pkg::LEAD1_HI) ||
				(b >= sjis_pkg::LEAD2_LO && b <= sjis_pkg::LEAD2_HI)) begin
			lead_held = 1'b1;
			held_byte = b;
			return 1'b0;
		end
		if (builtin_mode) begin
			g.builtin_font = 1'b1;
			g.builtin_char = b;
			g.code_mapped  = 1'b1;
		end else if (b >= sjis_pkg::ASCII_LO && b <= sjis_pkg::ASCII_HI) begin
			g.rom_address = addr_t'((int'(b) - int'(sjis_pkg::ASCII_LO)) * NARROW_BYTES
				+ int'(sjis_pkg::BASE_ASCII));
			g.code_mapped = 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic check_glyph(input sjis_pkg::sjis_res_t got);
		sjis_pkg::sjis_res_t want;
		if (pending_glyphs.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual addr %0d wide %0b",
				$time, got.rom_address, got.wide_glyph);
			n_errors++;
			return;
		end
		want = pending_glyphs.pop_front();
		if (got.rom_address !== want.rom_address) begin
			$display("%0t: rom_address expected %0d actual %0d", $time,
				want.rom_address, got.rom_address);
			n_errors++;
		end
		if (got.wide_glyph !== want.wide_glyph) begin
			$display("%0t: wide_glyph expected %0b actual %0b", $time,
				want.wide_glyph, got.wide_glyph);
			n_errors++;
		end
		if (got.builtin_font !== want.builtin_font) begin
			$display("%0t: builtin_font expected %0b actual %0b", $time,
				want.builtin_font, got.builtin_font);
			n_errors++;
		end
		if (got.builtin_char !== want.builtin_char) begin
			$display("%0t: builtin_char expected %0h actual %0h", $time,
				want.builtin_char, got.builtin_char);
			n_errors++;
		end
		if (got.code_mapped !== want.code_mapped) begin
			$display("%0t: code_mapped expected %0b actual %0b", $time,
				want.code_mapped, got.code_mapped);
			n_errors++;
		end
	endtask

	// Monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		sjis_pkg::sjis_res_t pred;
		bit                  has_glyph;
		if (arst_n) begin
			if (cfg_wr_en)
				builtin_mode = cfg_wr_data;
			if (in_valid && in_ready) begin
				has_glyph = predict_glyph(text_byte, pred);
				if (has_glyph)
					pending_glyphs.push_back(item_typed ? item_glyph : pred);
			end
			if (out_valid && out_ready)
				check_glyph({rom_address, wide_glyph, builtin_font, builtin_char, code_mapped});
		end
	end

	// Watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("sjis_font_rom_address_unit test failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			out_ready = jitter_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
		end
	end

	task automatic send_byte(input byte_t b, input bit typed = 1'b0,
			input sjis_pkg::sjis_res_t glyph = '0);
		while (jitter_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		text_byte  = b;
		item_typed = typed;
		item_glyph = glyph;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Register write once all results are back and the pipe has settled
	task automatic program_builtin(input logic value);
		in_valid = 1'b0;
		while (pending_glyphs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	function automatic byte_t pick_lead();
		if ($urandom_range(1))
			return byte_t'($urandom_range(sjis_pkg::LEAD1_LO, sjis_pkg::LEAD1_HI));
		return byte_t'($urandom_range(sjis_pkg::LEAD2_LO, sjis_pkg::LEAD2_HI));
	endfunction

	// Mostly well-formed text, with broken pairs, string ends and noise mixed in
	task automatic run_text_phase(input int n_bytes);
		int sent;
		int pick;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_byte(pick_lead());
				if ($urandom_range(1))
					send_byte(byte_t'($urandom_range(TRAIL_LO_MIN, TRAIL_LO_MAX)));
				else
					send_byte(byte_t'($urandom_range(TRAIL_HI_MIN, TRAIL_HI_MAX)));
				sent += 2;
			end else if (pick < 72) begin
				send_byte(byte_t'($urandom_range(sjis_pkg::ASCII_LO, sjis_pkg::ASCII_HI)));
				sent++;
			end else if (pick < 79) begin
				// lead cut off by end of string
				send_byte(pick_lead());
				send_byte(END_OF_STRING);
				sent += 2;
			end else if (pick < 86) begin
				// lead followed by any nonzero byte
				send_byte(pick_lead());
				send_byte(byte_t'($urandom_range(1, 255)));
				sent += 2;
			end else if (pick < 90) begin
				send_byte(END_OF_STRING);
				sent++;
			end else begin
				send_byte(byte_t'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	// Stimulus
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		text_byte   = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;

		directed_rows = '{
			'{ROW_CFG,  8'h00, 1'b0, '0},
			// half-width range ends and unmapped single bytes
			'{ROW_BYTE, 8'h20, 1'b1, {18'd255968, 1'b0, 1'b0, 8'h00, 1'b1}},
			'{ROW_BYTE, 8'h7F, 1'b1, {18'd257488, 1'b0, 1'b0, 8'h00, 1'b1}},
			'{ROW_BYTE, 8'h01, 1'b1, {18'd0, 1'b0, 1'b0, 8'h00, 1'b0}},
			'{ROW_BYTE, 8'h80, 1'b1, {18'd0, 1'b0, 1'b0, 8'h00, 1'b0}},
			'{ROW_BYTE, 8'hDF, 1'b1, {18'd0, 1'b0, 1'b0, 8'h00, 1'b0}},
			'{ROW_BYTE, 8'hFF, 1'b1, {18'd0, 1'b0, 1'b0, 8'h00, 1'b0}},
			// first glyph of the ROM: row 1, cell 1
			'{ROW_BYTE, 8'h81, 1'b0, '0},
			'{ROW_BYTE, 8'h40, 1'b1, {18'd0, 1'b1, 1'b0, 8'h00, 1'b1}},
			// end of string drops the held lead
			'{ROW_BYTE, 8'hE0, 1'b0, '0},
			'{ROW_BYTE, 8'h00, 1'b0, '0},
			'{ROW_BYTE, 8'h41, 1'b1, {18'd256496, 1'b0, 1'b0, 8'h00, 1'b1}},
			// band edges and the top lead/trail pair
			'{ROW_BYTE, 8'h9F, 1'b0, '0},
			'{ROW_BYTE, 8'hFC, 1'b0, '0},
			'{ROW_BYTE, 8'hFC, 1'b0, '0},
			'{ROW_BYTE, 8'hFC, 1'b0, '0},
			'{ROW_BYTE, 8'h88, 1'b0, '0},
			'{ROW_BYTE, 8'h9F, 1'b0, '0},
			'{ROW_BYTE, 8'hEB, 1'b0, '0},
			'{ROW_BYTE, 8'h40, 1'b0, '0},
			'{ROW_BYTE, 8'hEC, 1'b0, '0},
			'{ROW_BYTE, 8'h9F, 1'b0, '0},
			// junk trail still completes the pair
			'{ROW_BYTE, 8'h81, 1'b0, '0},
			'{ROW_BYTE, 8'h01, 1'b0, '0},
			// built-in font for single bytes, pairs unaffected
			'{ROW_CFG,  8'h01, 1'b0, '0},
			'{ROW_BYTE, 8'hFF, 1'b1, {18'd0, 1'b0, 1'b1, 8'hFF, 1'b1}},
			'{ROW_BYTE, 8'h81, 1'b0, '0},
			'{ROW_BYTE, 8'h40, 1'b1, {18'd0, 1'b1, 1'b0, 8'h00, 1'b1}}
		};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows, no idling
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				program_builtin(directed_rows[i].data[0]);
			else
				send_byte(directed_rows[i].data, directed_rows[i].typed,
					directed_rows[i].glyph);
		end

		// Random text, alternating the built-in font setting
		jitter_on = 1'b1;
		program_builtin(1'b0);
		run_text_phase(250);

		program_builtin(1'b1);
		hold_off_req = 1'b1;
		run_text_phase(200);

		jitter_on = 1'b0;
		program_builtin(1'b0);
		run_text_phase(250);

		jitter_on = 1'b1;
		program_builtin(1'b1);
		run_text_phase(150);

		program_builtin(1'b0);
		run_text_phase(150);

		in_valid = 1'b0;
		while (pending_glyphs.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (n_errors == 0)
			$display("sjis_font_rom_address_unit test passed");
		else
			$display("sjis_font_rom_address_unit test failed");
		$finish;
	end

endmodule
